// File: sv/lruol_pkg.sv
package lruol_pkg;

  localparam int SLOT_W_MAX = 10;
  localparam int IDX_W      = 6;

  localparam logic OP_TOUCH  = 1'b0;
  localparam logic OP_DEMOTE = 1'b1;

  typedef logic [SLOT_W_MAX-1:0] slot_t;

  typedef struct packed {
    logic  en;
    logic  touch;
    logic  s_at_end;
    slot_t s;
    slot_t p;
    slot_t n;
    slot_t h;
    slot_t t;
  } upd_t;

endpackage

// File: sv/lruol_cell.sv
module lruol_cell import lruol_pkg::*; #(
  parameter int SLOTS = 64,
  parameter int ID    = 0,
  parameter int LW    = $clog2(SLOTS)
) (
  input  logic          clk,
  input  logic          rst,
  input  upd_t          upd,
  output logic [LW-1:0] nxt,
  output logic [LW-1:0] prv
);

  localparam logic [LW-1:0] NXT_RST = LW'((ID + 1) % SLOTS);
  localparam logic [LW-1:0] PRV_RST = LW'((ID + SLOTS - 1) % SLOTS);
  localparam slot_t         MY_ID   = slot_t'(ID);

  logic          is_s;
  logic          is_p;
  logic          is_n;
  logic          is_h;
  logic          is_t;
  logic          relink;
  logic [LW-1:0] nxt_next;
  logic [LW-1:0] prv_next;

  assign is_s   = (upd.s == MY_ID);
  assign is_p   = (upd.p == MY_ID);
  assign is_n   = (upd.n == MY_ID);
  assign is_h   = (upd.h == MY_ID);
  assign is_t   = (upd.t == MY_ID);
  assign relink = !upd.s_at_end;

  always_comb begin
    nxt_next = nxt;
    prv_next = prv;
    if (upd.touch) begin
      if (is_s) begin
        nxt_next = upd.h[LW-1:0];
      end else if (is_p && relink) begin
        nxt_next = upd.n[LW-1:0];
      end
      if (is_h) begin
        prv_next = upd.s[LW-1:0];
      end else if (is_n && relink) begin
        prv_next = upd.p[LW-1:0];
      end
    end else begin
      if (is_t) begin
        nxt_next = upd.s[LW-1:0];
      end else if (is_p && relink) begin
        nxt_next = upd.n[LW-1:0];
      end
      if (is_s) begin
        prv_next = upd.t[LW-1:0];
      end else if (is_n && relink) begin
        prv_next = upd.p[LW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nxt <= NXT_RST;
      prv <= PRV_RST;
    end else if (upd.en) begin
      nxt <= nxt_next;
      prv <= prv_next;
    end
  end

endmodule

// File: sv/lru_order_list.sv
// LRU recency order over SLOTS cache slots, kept as a doubly linked list.
// Input channel s_*: one beat per request. s_tuser[0] is the operation
// (0 = touch, move slot to head; 1 = demote, move slot to tail) and
// s_tdata[5:0] the slot index. Indexes not below SLOTS are ignored.
// Output channel m_*: one beat per request with the new head, the new
// tail (eviction victim) and a moved flag.
// Each slot's links live in a cell of its own; a request reads the slot's
// neighbors from the cells, then every cell updates itself in parallel from
// the broadcast request. An item goes through accept, link read and
// update, and the input stays closed until its update commits; the result
// register is loaded at that update.
// The next request is taken while a result waits in the output register;
// if the receiver stalls, the update of that next request waits until the
// pending result is taken, and the input stays closed meanwhile.
// Reset (synchronous) puts the order back to slot 0 at the head through
// slot SLOTS-1 at the tail and empties the output register.
module lru_order_list import lruol_pkg::*; #(
  parameter int SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [5:0] slot, [7:6] zero
  input  logic [0:0]  s_tuser,   // [0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [5:0] head_slot, [11:6] tail_slot, [12] moved, [15:13] zero
);

  localparam int LW = $clog2(SLOTS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic             op_r;
  logic [LW-1:0]    s_r;
  logic             hit;
  logic [LW-1:0]    p_r;
  logic [LW-1:0]    n_r;
  logic [LW-1:0]    head;
  logic [LW-1:0]    tail;
  logic [LW-1:0]    head_next;
  logic [LW-1:0]    tail_next;
  logic             moved_next;
  logic             commit;
  logic             out_valid;
  logic [5:0]       out_head;
  logic [5:0]       out_tail;
  logic             out_moved;
  logic [31:0]      idx_ext;
  logic [31:0]      head_ext;
  logic [31:0]      tail_ext;
  logic             s_at_head;
  logic             s_at_tail;
  upd_t             upd;
  logic [LW-1:0]    nxt_lnk [SLOTS];
  logic [LW-1:0]    prv_lnk [SLOTS];

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_moved, out_tail, out_head};

  assign idx_ext   = 32'(s_tdata[IDX_W-1:0]);
  assign s_at_head = (s_r == head);
  assign s_at_tail = (s_r == tail);
  assign commit    = (state == ST_WRITE) && (!out_valid || m_tready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_READ;
      ST_READ:  state_next = ST_WRITE;
      ST_WRITE: if (commit) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    moved_next = 1'b0;
    if (hit) begin
      if (op_r == OP_TOUCH) begin
        if (!s_at_head) begin
          moved_next = 1'b1;
          head_next  = s_r;
          if (s_at_tail) tail_next = p_r;
        end
      end else begin
        if (!s_at_tail) begin
          moved_next = 1'b1;
          tail_next  = s_r;
          if (s_at_head) head_next = n_r;
        end
      end
    end
  end

  always_comb begin
    upd.en       = commit && moved_next;
    upd.touch    = (op_r == OP_TOUCH);
    upd.s_at_end = (op_r == OP_TOUCH) ? s_at_tail : s_at_head;
    upd.s        = slot_t'(s_r);
    upd.p        = slot_t'(p_r);
    upd.n        = slot_t'(n_r);
    upd.h        = slot_t'(head);
    upd.t        = slot_t'(tail);
  end

  assign head_ext = 32'(head_next);
  assign tail_ext = 32'(tail_next);

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    lruol_cell #(
      .SLOTS (SLOTS),
      .ID    (i),
      .LW    (LW)
    ) u_cell (
      .clk (clk),
      .rst (rst),
      .upd (upd),
      .nxt (nxt_lnk[i]),
      .prv (prv_lnk[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      head      <= '0;
      tail      <= LW'(SLOTS - 1);
    end else begin
      state <= state_next;
      if (commit) begin
        out_valid <= 1'b1;
        head      <= head_next;
        tail      <= tail_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_r  <= s_tuser[0];
      s_r   <= idx_ext[LW-1:0];
      hit   <= (idx_ext < 32'(SLOTS));
    end
    if (state == ST_READ && hit) begin
      p_r <= prv_lnk[s_r];
      n_r <= nxt_lnk[s_r];
    end
    if (commit) begin
      out_head  <= head_ext[5:0];
      out_tail  <= tail_ext[5:0];
      out_moved <= moved_next;
    end
  end

endmodule

// File: sv/lruol_checker.sv
module lruol_checker import lruol_pkg::*; #(
  parameter int SLOTS = 64
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic [0:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  logic [IDX_W-1:0] last_idx;
  logic             last_op;
  logic [1:0]       pend;

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      last_idx <= s_tdata[IDX_W-1:0];
      last_op  <= s_tuser[0];
    end
  end

  // requests accepted whose result beat has not been taken yet
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend + 2'(s_tvalid && s_tready) - 2'(m_tvalid && m_tready);
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input reopened while request in flight");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  a_ends_differ: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((SLOTS > 64) || (m_tdata[5:0] != m_tdata[11:6])))
    else $error("head equals tail");

  a_touch_head: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && pend == 2'd1 && m_tdata[12] && last_op == OP_TOUCH)
    |-> (m_tdata[5:0] == last_idx))
    else $error("touched slot not at head");

endmodule

bind lru_order_list lruol_checker #(.SLOTS(SLOTS)) u_lruol_checker (.*);
